@@ design/tlsi_pkg.sv @@
// ----------------------------------------------------------------------------
// tlsi_pkg: shared definitions for the two-axis line step interpolator
// Widths, operation codes, state encodings and the structs passed between
// the top level, the ratio sequencer and the step generator.
// ----------------------------------------------------------------------------
`default_nettype none

package tlsi_pkg;

   // Width of a step count and of an axis position.
   localparam int STEP_BITS = 24;
   localparam int POS_BITS  = 32;

   // Fixed field widths on the stream ports.
   localparam int IN_STEP_BITS = 24;
   localparam int OUT_POS_BITS = 32;
   localparam int REQ_DATA_BITS = 56;
   localparam int RSP_DATA_BITS = 72;

   // Error accumulator: signed, with headroom above twice the denominator.
   localparam int ERR_BITS = STEP_BITS + 3;

   // Shared subtract unit width: one bit above a step count.
   localparam int SUB_BITS = STEP_BITS + 1;

   // Division bit counter and gcd shift count.
   localparam int CNT_BITS = $clog2(STEP_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(STEP_BITS - 1);

   // Operation selector carried in tuser.
   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_ZERO_X = 2'd2,
      OP_ZERO_Z = 2'd3
   } op_type;

   // Top level sequencer.
   typedef enum logic {
      T_IDLE,
      T_WAIT
   } top_state_type;

   // Ratio sequencer.
   typedef enum logic [2:0] {
      R_IDLE,
      R_GCD,
      R_DIV_X,
      R_DIV_Z,
      R_DONE
   } ratio_state_type;

   // Command to the step generator for one transaction.
   typedef struct packed {
      logic tick;
      logic zero_x;
      logic zero_z;
      logic load;
      logic x_neg;
      logic z_neg;
   } step_cmd_type;

   // Reduced line setup produced by the ratio sequencer.
   typedef struct packed {
      logic [STEP_BITS-1:0] num;
      logic [STEP_BITS-1:0] den;
      logic                 z_major;
      logic [STEP_BITS-1:0] x_steps;
      logic [STEP_BITS-1:0] z_steps;
   } ratio_type;

   // Visible state of the step generator.
   typedef struct packed {
      logic                x_level;
      logic                z_level;
      logic                x_neg;
      logic                z_neg;
      logic                moving;
      logic [POS_BITS-1:0] x_pos;
      logic [POS_BITS-1:0] z_pos;
   } view_type;

   // Bring a position to the 32-bit port field (zero filled when narrower).
   function automatic logic [OUT_POS_BITS-1:0] pos_to_port(input logic [POS_BITS-1:0] pos);
      logic [POS_BITS+OUT_POS_BITS-1:0] ext;
      ext = {{OUT_POS_BITS{1'b0}}, pos};
      return ext[OUT_POS_BITS-1:0];
   endfunction

   // Bring a 24-bit port step count to the internal width.
   function automatic logic [STEP_BITS-1:0] steps_from_port(
      input logic [IN_STEP_BITS-1:0] steps);
      logic [STEP_BITS+IN_STEP_BITS-1:0] ext;
      ext = {{STEP_BITS{1'b0}}, steps};
      return ext[STEP_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/tlsi_subtract.sv @@
// ----------------------------------------------------------------------------
// tlsi_subtract: shared subtract and compare unit
// Computes op_a - op_b and flags a borrow when op_b is the larger operand.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsi_subtract (
   input  wire logic [tlsi_pkg::SUB_BITS-1:0] op_a,
   input  wire logic [tlsi_pkg::SUB_BITS-1:0] op_b,
   output logic      [tlsi_pkg::SUB_BITS-1:0] diff,
   output logic                               borrow
);

   logic [tlsi_pkg::SUB_BITS:0] wide;

   // One extra bit catches the borrow out of the top.
   assign wide   = {1'b0, op_a} - {1'b0, op_b};
   assign diff   = wide[tlsi_pkg::SUB_BITS-1:0];
   assign borrow = wide[tlsi_pkg::SUB_BITS];

endmodule

`default_nettype wire

@@ design/tlsi_ratio.sv @@
// ----------------------------------------------------------------------------
// tlsi_ratio: step ratio sequencer
// Reduces the two step counts by their gcd with a binary gcd, then divides
// both counts by the odd part of the gcd with restoring division. All
// subtractions go through one shared subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsi_ratio (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [tlsi_pkg::STEP_BITS-1:0] x_steps,
   input  wire logic [tlsi_pkg::STEP_BITS-1:0] z_steps,
   output logic                                done,
   output tlsi_pkg::ratio_type                 result
);

   localparam int SB = tlsi_pkg::STEP_BITS;

   tlsi_pkg::ratio_state_type state_ff, state_in;

   logic [SB-1:0]                   xs_ff, xs_in;
   logic [SB-1:0]                   zs_ff, zs_in;
   logic                            zmaj_ff, zmaj_in;
   logic [SB-1:0]                   a_ff, a_in;
   logic [SB-1:0]                   b_ff, b_in;
   logic [tlsi_pkg::CNT_BITS-1:0]   k_ff, k_in;
   logic [SB-1:0]                   div_ff, div_in;
   logic [SB-1:0]                   rem_ff, rem_in;
   logic [SB-1:0]                   quo_ff, quo_in;
   logic [SB-1:0]                   qx_ff, qx_in;
   logic [tlsi_pkg::CNT_BITS-1:0]   cnt_ff, cnt_in;

   logic [tlsi_pkg::SUB_BITS-1:0]   op_a;
   logic [tlsi_pkg::SUB_BITS-1:0]   op_b;
   logic [tlsi_pkg::SUB_BITS-1:0]   diff;
   logic                            borrow;
   logic                            gcd_end;
   logic                            div_last;
   logic [SB-1:0]                   quo_step;
   logic [SB-1:0]                   rem_step;

   // Shared subtract unit.
   tlsi_subtract u_subtract (
      .op_a   (op_a),
      .op_b   (op_b),
      .diff   (diff),
      .borrow (borrow)
   );

   // The gcd loop ends once either operand reaches zero.
   assign gcd_end  = (a_ff == '0) || (b_ff == '0);
   assign div_last = (cnt_ff == '0);

   // Restoring division step on the shared result.
   assign quo_step = {quo_ff[SB-2:0], ~borrow};
   assign rem_step = borrow ? op_a[SB-1:0] : diff[SB-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlsi_pkg::R_IDLE: begin
            if (start) begin
               state_in = tlsi_pkg::R_GCD;
            end
         end
         tlsi_pkg::R_GCD: begin
            if (gcd_end) begin
               state_in = tlsi_pkg::R_DIV_X;
            end
         end
         tlsi_pkg::R_DIV_X: begin
            if (div_last) begin
               state_in = tlsi_pkg::R_DIV_Z;
            end
         end
         tlsi_pkg::R_DIV_Z: begin
            if (div_last) begin
               state_in = tlsi_pkg::R_DONE;
            end
         end
         tlsi_pkg::R_DONE: begin
            state_in = tlsi_pkg::R_IDLE;
         end
         default: begin
            state_in = tlsi_pkg::R_IDLE;
         end
      endcase
   end

   // Outputs: shared unit operands and the reduced ratio.
   always_comb begin
      op_a = {1'b0, a_ff};
      op_b = {1'b0, b_ff};
      done = 1'b0;
      unique case (state_ff) inside
         tlsi_pkg::R_DIV_X, tlsi_pkg::R_DIV_Z: begin
            op_a = {rem_ff, quo_ff[SB-1]};
            op_b = {1'b0, div_ff};
         end
         tlsi_pkg::R_DONE: begin
            done = 1'b1;
         end
         default: begin
         end
      endcase
      result.num     = zmaj_ff ? qx_ff : quo_ff;
      result.den     = zmaj_ff ? quo_ff : qx_ff;
      result.z_major = zmaj_ff;
      result.x_steps = xs_ff;
      result.z_steps = zs_ff;
   end

   // Datapath registers.
   always_comb begin
      xs_in   = xs_ff;
      zs_in   = zs_ff;
      zmaj_in = zmaj_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      k_in    = k_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      qx_in   = qx_ff;
      cnt_in  = cnt_ff;
      unique case (state_ff)
         tlsi_pkg::R_IDLE: begin
            if (start) begin
               xs_in   = x_steps;
               zs_in   = z_steps;
               zmaj_in = z_steps > x_steps;
               a_in    = x_steps;
               b_in    = z_steps;
               k_in    = '0;
            end
         end
         tlsi_pkg::R_GCD: begin
            if (gcd_end) begin
               // Divisor is the odd part of the gcd; both counts zero gives one.
               if (a_ff == '0) begin
                  div_in = (b_ff == '0) ? SB'(1) : b_ff;
               end else begin
                  div_in = a_ff;
               end
               quo_in = xs_ff >> k_ff;
               rem_in = '0;
               cnt_in = tlsi_pkg::CNT_LAST;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + tlsi_pkg::CNT_BITS'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (!borrow) begin
               a_in = diff[SB-1:0];
            end else begin
               // Keep the larger operand in a for the next subtraction.
               a_in = b_ff;
               b_in = a_ff;
            end
         end
         tlsi_pkg::R_DIV_X: begin
            if (div_last) begin
               qx_in  = quo_step;
               quo_in = zs_ff >> k_ff;
               rem_in = '0;
               cnt_in = tlsi_pkg::CNT_LAST;
            end else begin
               quo_in = quo_step;
               rem_in = rem_step;
               cnt_in = cnt_ff - tlsi_pkg::CNT_BITS'(1);
            end
         end
         tlsi_pkg::R_DIV_Z: begin
            quo_in = quo_step;
            rem_in = rem_step;
            cnt_in = cnt_ff - tlsi_pkg::CNT_BITS'(1);
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tlsi_pkg::R_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      xs_ff   <= xs_in;
      zs_ff   <= zs_in;
      zmaj_ff <= zmaj_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      div_ff  <= div_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      qx_ff   <= qx_in;
      cnt_ff  <= cnt_in;
   end

endmodule

`default_nettype wire

@@ design/tlsi_stepper.sv @@
// ----------------------------------------------------------------------------
// tlsi_stepper: two-axis step pulse generator
// Holds the line state and advances it by one tick: toggles the major
// pulse, counts major steps on falling edges, accumulates the ratio error
// and toggles the minor pulse on an error hit, when pending or at major end.
// ----------------------------------------------------------------------------
`default_nettype none

module tlsi_stepper (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tlsi_pkg::step_cmd_type cmd,
   input  wire tlsi_pkg::ratio_type  setup,
   output logic                      moving,
   output tlsi_pkg::view_type        view_next
);

   localparam int SB = tlsi_pkg::STEP_BITS;
   localparam int PB = tlsi_pkg::POS_BITS;
   localparam int EB = tlsi_pkg::ERR_BITS;

   logic [SB-1:0]        x_left_ff, x_left_in;
   logic [SB-1:0]        z_left_ff, z_left_in;
   logic [SB-1:0]        num_ff, num_in;
   logic [SB-1:0]        den_ff, den_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic                 zmaj_ff, zmaj_in;
   logic                 x_level_ff, x_level_in;
   logic                 z_level_ff, z_level_in;
   logic                 pend_ff, pend_in;
   logic                 x_neg_ff, x_neg_in;
   logic                 z_neg_ff, z_neg_in;
   logic                 moving_ff, moving_in;
   logic [PB-1:0]        x_pos_ff, x_pos_in;
   logic [PB-1:0]        z_pos_ff, z_pos_in;

   // Major / minor view of the axes.
   logic [SB-1:0]        maj_left, min_left, maj_left_n, min_left_n;
   logic                 maj_level, min_level, maj_level_n, min_level_n;
   logic [PB-1:0]        maj_pos, min_pos, maj_pos_n, min_pos_n;
   logic                 maj_neg, min_neg;
   logic                 maj_step, min_active, fire, hit, pend_n;
   logic signed [EB-1:0] n_ext, d_ext, err1, err_sum, err2;

   assign n_ext = $signed({{(EB-SB){1'b0}}, num_ff});
   assign d_ext = $signed({{(EB-SB){1'b0}}, den_ff});

   // One tick of the line, seen from the major axis.
   always_comb begin
      maj_left  = zmaj_ff ? z_left_ff : x_left_ff;
      min_left  = zmaj_ff ? x_left_ff : z_left_ff;
      maj_level = zmaj_ff ? z_level_ff : x_level_ff;
      min_level = zmaj_ff ? x_level_ff : z_level_ff;
      maj_pos   = zmaj_ff ? z_pos_ff : x_pos_ff;
      min_pos   = zmaj_ff ? x_pos_ff : z_pos_ff;
      maj_neg   = zmaj_ff ? z_neg_ff : x_neg_ff;
      min_neg   = zmaj_ff ? x_neg_ff : z_neg_ff;

      // Major axis: a step is counted on the falling edge of its pulse.
      maj_step    = (maj_left != '0) && maj_level;
      maj_left_n  = maj_step ? maj_left - SB'(1) : maj_left;
      maj_level_n = (maj_left != '0) ? ~maj_level : maj_level;
      maj_pos_n   = maj_step ? maj_pos + (maj_neg ? {PB{1'b1}} : PB'(1)) : maj_pos;

      // Error grows only while the minor axis still has steps to make.
      min_active = (min_left != '0);
      err1       = (maj_step && min_active) ? err_ff + n_ext : err_ff;
      err_sum    = err1 + n_ext;
      hit        = zmaj_ff ? (err_sum > d_ext) : (err1 >= d_ext);
      fire       = min_active && (hit || pend_ff || (maj_left_n == '0));
      err2       = (fire && hit) ? err1 - d_ext : err1;

      // Minor axis: toggle when fired, count a step on the falling edge.
      min_left_n  = min_left;
      min_level_n = min_level;
      min_pos_n   = min_pos;
      pend_n      = pend_ff;
      if (fire) begin
         min_level_n = ~min_level;
         if (min_level) begin
            pend_n     = 1'b0;
            min_left_n = min_left - SB'(1);
            min_pos_n  = min_pos + (min_neg ? {PB{1'b1}} : PB'(1));
         end else begin
            pend_n = 1'b1;
         end
      end
   end

   // Next line state for the command of this transaction.
   always_comb begin
      x_left_in  = x_left_ff;
      z_left_in  = z_left_ff;
      num_in     = num_ff;
      den_in     = den_ff;
      err_in     = err_ff;
      zmaj_in    = zmaj_ff;
      x_level_in = x_level_ff;
      z_level_in = z_level_ff;
      pend_in    = pend_ff;
      x_neg_in   = x_neg_ff;
      z_neg_in   = z_neg_ff;
      moving_in  = moving_ff;
      x_pos_in   = x_pos_ff;
      z_pos_in   = z_pos_ff;
      if (cmd.tick && moving_ff) begin
         x_left_in  = zmaj_ff ? min_left_n : maj_left_n;
         z_left_in  = zmaj_ff ? maj_left_n : min_left_n;
         x_level_in = zmaj_ff ? min_level_n : maj_level_n;
         z_level_in = zmaj_ff ? maj_level_n : min_level_n;
         x_pos_in   = zmaj_ff ? min_pos_n : maj_pos_n;
         z_pos_in   = zmaj_ff ? maj_pos_n : min_pos_n;
         err_in     = err2;
         pend_in    = pend_n;
         moving_in  = (maj_left_n != '0) || (min_left_n != '0);
      end
      if (cmd.load) begin
         x_left_in = setup.x_steps;
         z_left_in = setup.z_steps;
         num_in    = setup.num;
         den_in    = setup.den;
         zmaj_in   = setup.z_major;
         x_neg_in  = cmd.x_neg;
         z_neg_in  = cmd.z_neg;
         err_in    = '0;
         moving_in = 1'b1;
      end
      if (cmd.zero_x) begin
         x_pos_in = '0;
      end
      if (cmd.zero_z) begin
         z_pos_in = '0;
      end
   end

   // Visible state after this transaction.
   always_comb begin
      view_next.x_level = x_level_in;
      view_next.z_level = z_level_in;
      view_next.x_neg   = x_neg_in;
      view_next.z_neg   = z_neg_in;
      view_next.moving  = moving_in;
      view_next.x_pos   = x_pos_in;
      view_next.z_pos   = z_pos_in;
   end

   assign moving = moving_ff;

   // Line state registers, all cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_left_ff  <= '0;
         z_left_ff  <= '0;
         num_ff     <= '0;
         den_ff     <= '0;
         err_ff     <= '0;
         zmaj_ff    <= 1'b0;
         x_level_ff <= 1'b0;
         z_level_ff <= 1'b0;
         pend_ff    <= 1'b0;
         x_neg_ff   <= 1'b0;
         z_neg_ff   <= 1'b0;
         moving_ff  <= 1'b0;
         x_pos_ff   <= '0;
         z_pos_ff   <= '0;
      end else begin
         x_left_ff  <= x_left_in;
         z_left_ff  <= z_left_in;
         num_ff     <= num_in;
         den_ff     <= den_in;
         err_ff     <= err_in;
         zmaj_ff    <= zmaj_in;
         x_level_ff <= x_level_in;
         z_level_ff <= z_level_in;
         pend_ff    <= pend_in;
         x_neg_ff   <= x_neg_in;
         z_neg_ff   <= z_neg_in;
         moving_ff  <= moving_in;
         x_pos_ff   <= x_pos_in;
         z_pos_ff   <= z_pos_in;
      end
   end

endmodule

`default_nettype wire

@@ design/two_axis_line_step_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// two_axis_line_step_interpolator_unit: two-axis line step pulse generator
// Each request transaction carries one operation in req_tuser (tick, start
// a line move, zero the x position, zero the z position) and yields exactly
// one response transaction with the pulse pins, direction pins, busy flag
// and both positions as they stand after the operation.
// A tick, a position clear, or a start that arrives while a move is in
// progress is answered the cycle after acceptance. A start taken while idle
// runs the ratio sequencer first: a binary gcd of the two step counts and
// two restoring divisions of STEP_BITS steps each, all on one shared
// subtract unit; the response is registered when the sequencer finishes.
// req_tready is low while the sequencer runs and while an undelivered
// response sits in the output register and rsp_tready is low; the output
// register drains and refills in the same cycle, so ticks sustain one
// transaction per cycle while the receiver keeps up.
// Synchronous reset clears the line state, both positions and the output
// valid flag; no response is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module two_axis_line_step_interpolator_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request: tuser [1:0] opcode.
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [1:0]                          req_tuser,
   // Request tdata: [23:0] x_steps, [47:24] z_steps, [48] x_backward,
   // [49] z_backward, [55:50] zero.
   input  wire logic [tlsi_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // Response tdata: [0] accepted, [1] x_pulse, [2] z_pulse, [3] x_dir_pin,
   // [4] z_dir_pin, [5] busy_res, [37:6] x_position, [69:38] z_position,
   // [71:70] zero.
   output logic [tlsi_pkg::RSP_DATA_BITS-1:0]       rsp_tdata
);

   tlsi_pkg::top_state_type state_ff, state_in;

   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [tlsi_pkg::RSP_DATA_BITS-1:0]     rsp_data_ff, rsp_data_in;
   logic                                   x_dir_ff, x_dir_in;
   logic                                   z_dir_ff, z_dir_in;

   tlsi_pkg::op_type                       op;
   tlsi_pkg::step_cmd_type                 cmd;
   tlsi_pkg::ratio_type                    setup;
   tlsi_pkg::view_type                     view_next;
   logic                                   req_fire;
   logic                                   ratio_start;
   logic                                   ratio_done;
   logic                                   moving;
   logic                                   load_rsp;
   logic [tlsi_pkg::STEP_BITS-1:0]         x_steps;
   logic [tlsi_pkg::STEP_BITS-1:0]         z_steps;

   assign op      = tlsi_pkg::op_type'(req_tuser);
   assign x_steps = tlsi_pkg::steps_from_port(req_tdata[23:0]);
   assign z_steps = tlsi_pkg::steps_from_port(req_tdata[47:24]);

   // Ratio sequencer with the shared subtract unit.
   tlsi_ratio u_ratio (
      .clock   (clock),
      .reset   (reset),
      .start   (ratio_start),
      .x_steps (x_steps),
      .z_steps (z_steps),
      .done    (ratio_done),
      .result  (setup)
   );

   // Line state and pulse generation.
   tlsi_stepper u_stepper (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .setup     (setup),
      .moving    (moving),
      .view_next (view_next)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlsi_pkg::T_IDLE: begin
            if (ratio_start) begin
               state_in = tlsi_pkg::T_WAIT;
            end
         end
         tlsi_pkg::T_WAIT: begin
            if (ratio_done) begin
               state_in = tlsi_pkg::T_IDLE;
            end
         end
         default: begin
            state_in = tlsi_pkg::T_IDLE;
         end
      endcase
   end

   // Outputs: handshake and the step generator command.
   always_comb begin
      req_tready  = 1'b0;
      ratio_start = 1'b0;
      cmd         = '0;
      cmd.x_neg   = x_dir_ff;
      cmd.z_neg   = z_dir_ff;
      load_rsp    = 1'b0;
      req_fire    = 1'b0;
      unique case (state_ff)
         tlsi_pkg::T_IDLE: begin
            req_tready = !rsp_valid_ff || rsp_tready;
            req_fire   = req_tvalid && req_tready;
            if (req_fire) begin
               unique case (op)
                  tlsi_pkg::OP_TICK:   cmd.tick   = 1'b1;
                  tlsi_pkg::OP_ZERO_X: cmd.zero_x = 1'b1;
                  tlsi_pkg::OP_ZERO_Z: cmd.zero_z = 1'b1;
                  tlsi_pkg::OP_START:  ratio_start = !moving;
                  default: begin
                  end
               endcase
               load_rsp = !ratio_start;
            end
         end
         tlsi_pkg::T_WAIT: begin
            cmd.load = ratio_done;
            load_rsp = ratio_done;
         end
         default: begin
         end
      endcase
   end

   // Direction capture and response register.
   always_comb begin
      x_dir_in = x_dir_ff;
      z_dir_in = z_dir_ff;
      if (ratio_start) begin
         x_dir_in = req_tdata[48];
         z_dir_in = req_tdata[49];
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {2'b00,
                         tlsi_pkg::pos_to_port(view_next.z_pos),
                         tlsi_pkg::pos_to_port(view_next.x_pos),
                         view_next.moving,
                         view_next.z_neg,
                         view_next.x_neg,
                         view_next.z_level,
                         view_next.x_level,
                         ratio_done};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlsi_pkg::T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      x_dir_ff    <= x_dir_in;
      z_dir_ff    <= z_dir_in;
   end

   // The ratio sequencer finishes only while the top level waits for it.
   assert property (@(posedge clock) disable iff (reset)
      ratio_done |-> (state_ff == tlsi_pkg::T_WAIT))
      else $error("ratio done outside of a line start");

   // A finished start yields a response marked accepted and busy.
   assert property (@(posedge clock) disable iff (reset)
      ratio_done |=> (rsp_tvalid && rsp_tdata[0] && rsp_tdata[5]))
      else $error("line start response missing or wrong");

   // A start that arrives during a move does not launch the sequencer.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (op == tlsi_pkg::OP_START) && moving)
      |=> (state_ff == tlsi_pkg::T_IDLE) && rsp_tvalid && !rsp_tdata[0])
      else $error("start during a move was not rejected");

   // No request is taken while the sequencer runs.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlsi_pkg::T_WAIT) |-> !req_tready)
      else $error("request taken during ratio computation");

endmodule

`default_nettype wire
